>>> rtl/ced_pkg.sv
// Shared types, byte codes and the named-escape lookup for the escape decoder.
package ced_pkg;

    localparam logic [7:0] CHAR_BACKSLASH = 8'h5c;
    localparam logic [7:0] CHAR_QUOTE     = 8'h22;
    localparam logic [7:0] CHAR_APOS      = 8'h27;
    localparam logic [7:0] CHAR_QMARK     = 8'h3f;
    localparam logic [1:0] OCTAL_MAX_DIGITS = 2'd3;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_ESC    = 2'd1,
        MODE_OCT    = 2'd2
    } mode_t;

    // One queue entry holds all results of one input byte.
    typedef struct packed {
        logic [7:0] byte0;
        logic       has0;
        logic [7:0] byte1;
        logic       two;
        logic       last;
    } entry_t;

    typedef struct packed {
        logic [8:0] code; // {hit, byte}
    } named_t;

    function automatic named_t named_code(input logic [7:0] b);
        named_t r;
        r.code = 9'd0;
        unique case (b)
            CHAR_APOS:      r.code = {1'b1, 8'h27};
            CHAR_QUOTE:     r.code = {1'b1, 8'h22};
            CHAR_QMARK:     r.code = {1'b1, 8'h3f};
            CHAR_BACKSLASH: r.code = {1'b1, 8'h5c};
            8'h61:          r.code = {1'b1, 8'h07};
            8'h62:          r.code = {1'b1, 8'h08};
            8'h66:          r.code = {1'b1, 8'h0c};
            8'h6e:          r.code = {1'b1, 8'h0a};
            8'h72:          r.code = {1'b1, 8'h0d};
            8'h74:          r.code = {1'b1, 8'h09};
            8'h76:          r.code = {1'b1, 8'h0b};
            default:        r.code = 9'd0;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/ced_front.sv
// Front end: accepts input bytes, tracks the escape state and builds queue entries.
module ced_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic [7:0]      in_byte,
    input  logic            in_last,
    input  logic            q_full,
    output logic            in_ready,
    output logic            push,
    output ced_pkg::entry_t push_entry
);

    ced_pkg::mode_t mode_reg, mode_next;
    logic [7:0]     oval_reg, oval_next;
    logic [1:0]     odig_reg, odig_next;

    logic           accept;
    logic           is_oct;
    logic [2:0]     digit;
    logic [7:0]     shifted;
    logic [1:0]     dig_inc;
    ced_pkg::named_t named;
    logic [1:0]     n;
    ced_pkg::entry_t e;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign is_oct   = (in_byte[7:3] == 5'b00110);
    assign digit    = in_byte[2:0];
    assign shifted  = {oval_reg[4:0], digit};
    assign dig_inc  = odig_reg + 2'd1;
    assign named    = ced_pkg::named_code(in_byte);

    always_comb
    begin
        logic plain;
        plain     = 1'b0;
        mode_next = mode_reg;
        oval_next = oval_reg;
        odig_next = odig_reg;
        n         = 2'd0;
        e         = '0;

        unique case (mode_reg)
            ced_pkg::MODE_ESC:
            begin
                if (named.code[8])
                begin
                    e.byte0   = named.code[7:0];
                    e.has0    = 1'b1;
                    n         = 2'd1;
                    mode_next = ced_pkg::MODE_NORMAL;
                end
                else if (is_oct)
                begin
                    mode_next = ced_pkg::MODE_OCT;
                    oval_next = {5'd0, digit};
                    odig_next = 2'd1;
                end
                else
                begin
                    plain = 1'b1;
                end
            end
            ced_pkg::MODE_OCT:
            begin
                if (is_oct)
                begin
                    if (dig_inc == ced_pkg::OCTAL_MAX_DIGITS)
                    begin
                        e.byte0   = shifted;
                        e.has0    = 1'b1;
                        n         = 2'd1;
                        mode_next = ced_pkg::MODE_NORMAL;
                        oval_next = 8'd0;
                        odig_next = 2'd0;
                    end
                    else
                    begin
                        oval_next = shifted;
                        odig_next = dig_inc;
                    end
                end
                else
                begin
                    // The run's byte goes out first, then the breaking byte as text.
                    e.byte0   = oval_reg;
                    e.has0    = 1'b1;
                    n         = 2'd1;
                    oval_next = 8'd0;
                    odig_next = 2'd0;
                    plain     = 1'b1;
                end
            end
            default:
            begin
                plain = 1'b1;
            end
        endcase

        if (plain)
        begin
            mode_next = ced_pkg::MODE_NORMAL;
            if (in_byte == ced_pkg::CHAR_BACKSLASH && !in_last)
            begin
                mode_next = ced_pkg::MODE_ESC;
            end
            else if (in_byte != ced_pkg::CHAR_QUOTE)
            begin
                if (n == 2'd0)
                begin
                    e.byte0 = in_byte;
                    e.has0  = 1'b1;
                end
                else
                begin
                    e.byte1 = in_byte;
                    e.two   = 1'b1;
                end
                n = n + 2'd1;
            end
        end

        if (in_last)
        begin
            // An open octal run is flushed at the end of the stream.
            if (mode_next == ced_pkg::MODE_OCT)
            begin
                if (n == 2'd0)
                begin
                    e.byte0 = oval_next;
                    e.has0  = 1'b1;
                end
                else
                begin
                    e.byte1 = oval_next;
                    e.two   = 1'b1;
                end
                n = n + 2'd1;
            end
            e.last    = 1'b1;
            mode_next = ced_pkg::MODE_NORMAL;
            oval_next = 8'd0;
            odig_next = 2'd0;
        end
    end

    assign push       = accept && ((n != 2'd0) || in_last);
    assign push_entry = e;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= ced_pkg::MODE_NORMAL;
            oval_reg <= 8'd0;
            odig_reg <= 2'd0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            oval_reg <= oval_next;
            odig_reg <= odig_next;
        end
    end

endmodule

>>> rtl/ced_queue.sv
// Two-entry queue of decoded entries between the front and back ends.
module ced_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  ced_pkg::entry_t push_entry,
    input  logic            pop,
    output logic            full,
    output logic            not_empty,
    output ced_pkg::entry_t head
);

    ced_pkg::entry_t mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> rtl/ced_back.sv
// Back end: sends the one or two results of the queue head, one per cycle while out_ready is high.
module ced_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  ced_pkg::entry_t head,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [7:0]      out_byte,
    output logic            out_has,
    output logic            out_last
);

    logic second_reg, second_next;
    logic fire;
    logic final_one;

    assign out_valid = q_valid;
    assign fire      = out_valid && out_ready;
    assign final_one = second_reg || !head.two;
    assign pop       = fire && final_one;

    assign out_byte = second_reg ? head.byte1 : head.byte0;
    assign out_has  = second_reg ? 1'b1 : head.has0;
    assign out_last = head.last && final_one;

    always_comb
    begin
        second_next = second_reg;
        if (fire)
        begin
            second_next = !final_one;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            second_reg <= 1'b0;
        end
        else
        begin
            second_reg <= second_next;
        end
    end

endmodule

>>> rtl/c_escape_sequence_decoder.sv
// Top level of the C-style escape decoder: front end, queue and back end.
// One input byte is accepted per cycle while the two-entry queue has room, and one
// result leaves per cycle while the sink is ready; a byte that yields two results (an
// octal run broken by a byte that is itself emitted) sends them one after the other,
// which can fill the queue and so hold off the input.
// A result is written into the queue when its byte is accepted. Results without data
// (has_data low in tuser) only appear as the last result of a stream.
module c_escape_sequence_decoder (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,  // [7:0] in_byte
    input  logic       s_tlast,  // in_last
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,  // [7:0] out_byte
    output logic       m_tuser,  // [0] has_data
    output logic       m_tlast   // out_last
);

    logic            q_full;
    logic            q_valid;
    logic            push;
    logic            pop;
    ced_pkg::entry_t push_entry;
    ced_pkg::entry_t head;

    ced_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_byte    (s_tdata),
        .in_last    (s_tlast),
        .q_full     (q_full),
        .in_ready   (s_tready),
        .push       (push),
        .push_entry (push_entry)
    );

    ced_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (q_full),
        .not_empty  (q_valid),
        .head       (head)
    );

    ced_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .head      (head),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_byte  (m_tdata),
        .out_has   (m_tuser),
        .out_last  (m_tlast)
    );

endmodule

>>> rtl/ced_checker.sv
// Port-level checks for the escape decoder, bound to its top level.
module ced_port_props (
    input logic       clk,
    input logic       rst_n,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tuser,
    input logic       m_tlast
);

    // A result held back by the sink stays offered.
    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped while stalled");

    // A stalled result keeps its payload.
    a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
        else $error("result payload changed while stalled");

    // An empty result only closes a stream and carries a zero byte.
    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tlast && (m_tdata == 8'd0))
        else $error("empty result that is not the end of a stream");

    // Input is only refused while results are waiting at the output.
    a_stall_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input refused with nothing pending");

endmodule

bind c_escape_sequence_decoder ced_port_props u_ced_port_props (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

>>> bench/ced_checker.sv
// Watches both streams of the escape decoder, predicts each result and compares it.
module ced_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,  // [7:0] in_byte
    input  logic       s_tlast,  // in_last
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,  // [7:0] out_byte
    input  logic       m_tuser,  // [0] has_data
    input  logic       m_tlast,  // out_last
    output int         errors,
    output int         pending
);

    typedef struct packed {
        logic [7:0] data;
        logic       has;
        logic       last;
    } decoded_t;

    decoded_t        expected_bytes[$];
    decoded_t        want;
    ced_pkg::mode_t  esc_mode;
    logic [7:0]      run_value;
    logic [1:0]      run_digits;

    // Returns {hit, code} for the character that follows a backslash.
    function automatic logic [8:0] escape_value(input logic [7:0] b);
        case (b)
            ced_pkg::CHAR_APOS, ced_pkg::CHAR_QUOTE,
            ced_pkg::CHAR_QMARK, ced_pkg::CHAR_BACKSLASH: return {1'b1, b};
            "a":     return {1'b1, 8'h07};
            "b":     return {1'b1, 8'h08};
            "f":     return {1'b1, 8'h0c};
            "n":     return {1'b1, 8'h0a};
            "r":     return {1'b1, 8'h0d};
            "t":     return {1'b1, 8'h09};
            "v":     return {1'b1, 8'h0b};
            default: return 9'd0;
        endcase
    endfunction

    function automatic logic octal_digit(input logic [7:0] b);
        return (b >= "0") && (b <= "7");
    endfunction

    task automatic decode_byte(input logic [7:0] b, input logic fin);
        decoded_t   res [2];
        int         n;
        logic [8:0] esc;
        logic       plain;
        n = 0;
        plain = 1'b0;
        esc = escape_value(b);
        case (esc_mode)
            ced_pkg::MODE_ESC:
            begin
                if (esc[8])
                begin
                    res[n] = '{esc[7:0], 1'b1, 1'b0};
                    n++;
                    esc_mode = ced_pkg::MODE_NORMAL;
                end
                else if (octal_digit(b))
                begin
                    esc_mode = ced_pkg::MODE_OCT;
                    run_value = b - "0";
                    run_digits = 2'd1;
                end
                else
                    plain = 1'b1;
            end
            ced_pkg::MODE_OCT:
            begin
                if (octal_digit(b))
                begin
                    run_value = {run_value[4:0], 3'b000} + (b - "0");
                    run_digits = run_digits + 2'd1;
                    if (run_digits == ced_pkg::OCTAL_MAX_DIGITS)
                    begin
                        res[n] = '{run_value, 1'b1, 1'b0};
                        n++;
                        esc_mode = ced_pkg::MODE_NORMAL;
                        run_value = '0;
                        run_digits = '0;
                    end
                end
                else
                begin
                    // The run's byte goes out first, then the breaking byte as text.
                    res[n] = '{run_value, 1'b1, 1'b0};
                    n++;
                    run_value = '0;
                    run_digits = '0;
                    plain = 1'b1;
                end
            end
            default:
                plain = 1'b1;
        endcase

        if (plain)
        begin
            esc_mode = ced_pkg::MODE_NORMAL;
            if (b == ced_pkg::CHAR_BACKSLASH && !fin)
                esc_mode = ced_pkg::MODE_ESC;
            else if (b != ced_pkg::CHAR_QUOTE)
            begin
                res[n] = '{b, 1'b1, 1'b0};
                n++;
            end
        end

        if (fin)
        begin
            if (esc_mode == ced_pkg::MODE_OCT)
            begin
                res[n] = '{run_value, 1'b1, 1'b0};
                n++;
            end
            if (n == 0)
            begin
                res[n] = '{8'h00, 1'b0, 1'b0};
                n++;
            end
            res[n-1].last = 1'b1;
            esc_mode = ced_pkg::MODE_NORMAL;
            run_value = '0;
            run_digits = '0;
        end

        for (int i = 0; i < n; i++)
            expected_bytes.push_back(res[i]);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_bytes.delete();
            esc_mode = ced_pkg::MODE_NORMAL;
            run_value = '0;
            run_digits = '0;
            errors = 0;
            pending = 0;
        end
        else
        begin
            // Results are registered in the queue before they leave, so the
            // output side is checked before this edge's request is predicted.
            if (m_tvalid && m_tready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result data %02h has %0b last %0b",
                             $time, m_tdata, m_tuser, m_tlast);
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (m_tdata !== want.data || m_tuser !== want.has ||
                        m_tlast !== want.last)
                    begin
                        errors++;
                        $display("%0t: expected %02h/%0b/%0b got %02h/%0b/%0b",
                                 $time, want.data, want.has, want.last,
                                 m_tdata, m_tuser, m_tlast);
                    end
                end
            end
            if (s_tvalid && s_tready)
                decode_byte(s_tdata, s_tlast);
            pending = expected_bytes.size();
        end
    end

endmodule

>>> bench/tb.sv
// Top of the escape decoder testbench: clock, reset, request and result traffic, verdict.
module tb;

    localparam int ITEM_TARGET  = 600;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_AT      = 150;
    localparam int HOLD_CYCLES  = 150;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } request_t;

    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       s_tvalid = 1'b0;
    logic [7:0] s_tdata  = 8'h00;
    logic       s_tlast  = 1'b0;
    logic       m_tready = 1'b0;
    wire        s_tready;
    wire        m_tvalid;
    wire  [7:0] m_tdata;
    wire        m_tuser;
    wire        m_tlast;

    int errors;
    int pending;
    int sent   = 0;
    int cycles = 0;
    int directed_count;
    int midpoint;

    request_t   requests[$];
    logic [7:0] escape_letters [11] = '{ced_pkg::CHAR_APOS, ced_pkg::CHAR_QUOTE,
                                        ced_pkg::CHAR_QMARK, ced_pkg::CHAR_BACKSLASH,
                                        "a", "b", "f", "n", "r", "t", "v"};

    c_escape_sequence_decoder u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    ced_checker u_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .errors   (errors),
        .pending  (pending)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic push_request(input logic [7:0] d, input logic l);
        requests.push_back('{d, l});
    endtask

    task automatic close_stream();
        request_t r;
        r = requests.pop_back();
        r.last = 1'b1;
        requests.push_back(r);
    endtask

    function automatic logic special_after_escape(input logic [7:0] b);
        if (b >= "0" && b <= "7")
            return 1'b1;
        foreach (escape_letters[i])
            if (escape_letters[i] == b)
                return 1'b1;
        return 1'b0;
    endfunction

    // Mostly well-formed escaped text; a share of stray backslashes and raw noise.
    task automatic add_stream();
        int         kind;
        logic [7:0] b;
        if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(1, 8))
                push_request(8'($urandom_range(0, 255)), 1'b0);
        end
        else
        begin
            repeat ($urandom_range(1, 12))
            begin
                kind = $urandom_range(0, 99);
                if (kind < 30)
                    push_request(8'($urandom_range(0, 255)), 1'b0);
                else if (kind < 50)
                begin
                    push_request(ced_pkg::CHAR_BACKSLASH, 1'b0);
                    push_request(escape_letters[$urandom_range(0, 10)], 1'b0);
                end
                else if (kind < 75)
                begin
                    push_request(ced_pkg::CHAR_BACKSLASH, 1'b0);
                    repeat ($urandom_range(1, 3))
                        push_request(8'("0" + $urandom_range(0, 7)), 1'b0);
                end
                else if (kind < 85)
                begin
                    push_request(ced_pkg::CHAR_BACKSLASH, 1'b0);
                    do
                        b = 8'($urandom_range(0, 255));
                    while (special_after_escape(b));
                    push_request(b, 1'b0);
                end
                else if (kind < 92)
                    push_request(ced_pkg::CHAR_QUOTE, 1'b0);
                else
                    push_request(ced_pkg::CHAR_BACKSLASH, 1'b0);
            end
        end
        close_stream();
    endtask

    task automatic build_requests();
        // Byte extremes, a dropped quote, a named and an unknown escape.
        push_request(8'h00, 1'b0);
        push_request(8'hff, 1'b0);
        push_request(ced_pkg::CHAR_QUOTE, 1'b0);
        push_request(ced_pkg::CHAR_BACKSLASH, 1'b0);
        push_request("n", 1'b0);
        push_request(ced_pkg::CHAR_BACKSLASH, 1'b0);
        push_request("q", 1'b0);
        // Three-digit runs, the second one wrapping past 8 bits.
        push_request(ced_pkg::CHAR_BACKSLASH, 1'b0);
        push_request("1", 1'b0);
        push_request("2", 1'b0);
        push_request("3", 1'b0);
        push_request(ced_pkg::CHAR_BACKSLASH, 1'b0);
        push_request("7", 1'b0);
        push_request("7", 1'b0);
        push_request("7", 1'b0);
        // A run broken by a letter on the final byte gives two results.
        push_request(ced_pkg::CHAR_BACKSLASH, 1'b0);
        push_request("4", 1'b0);
        push_request("x", 1'b1);
        // A backslash as the final byte.
        push_request(ced_pkg::CHAR_BACKSLASH, 1'b1);
        // A run still open at the final byte is flushed.
        push_request(ced_pkg::CHAR_BACKSLASH, 1'b0);
        push_request("5", 1'b1);
        // A final byte that yields no data, only an empty closing result.
        push_request(ced_pkg::CHAR_QUOTE, 1'b1);
        // A run broken by a non-octal digit at the end.
        push_request(ced_pkg::CHAR_BACKSLASH, 1'b0);
        push_request("1", 1'b0);
        push_request("9", 1'b1);
        directed_count = requests.size();
        while (requests.size() < ITEM_TARGET)
            add_stream();
        midpoint = requests.size() * 2 / 3;
    endtask

    // Sender: bursts of random length with random gaps, drained twice on the way.
    initial
    begin
        int idx;
        int burst;
        int gap;
        build_requests();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        idx = 0;
        while (idx < requests.size())
        begin
            burst = $urandom_range(1, 16);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            while (burst > 0 && idx < requests.size())
            begin
                if (idx == directed_count || idx == midpoint)
                begin
                    s_tvalid <= 1'b0;
                    wait (pending == 0);
                    @(negedge clk);
                end
                s_tvalid <= 1'b1;
                s_tdata  <= requests[idx].data;
                s_tlast  <= requests[idx].last;
                do
                    @(posedge clk);
                while (!s_tready);
                sent++;
                idx++;
                burst--;
                @(negedge clk);
            end
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        s_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Receiver: switches among always ready, coin toss and mostly stalled,
    // and once holds off long enough for the decoder to back up its input.
    initial
    begin
        int   style;
        int   span;
        logic held;
        style = 0;
        span  = 0;
        held  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!held && sent >= HOLD_AT)
            begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            if (span == 0)
            begin
                style = $urandom_range(0, 2);
                span  = $urandom_range(20, 80);
            end
            span--;
            case (style)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                default: m_tready <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
